[hw/rtl/gpe_pkg.sv]
// ----------------------------------------------------------------------------
// gpe_pkg
// Shared constants, codes and types of the glyph to pixel expander.
// ----------------------------------------------------------------------------
package gpe_pkg;

    localparam int GLYPH_WIDTH  = 5;
    localparam int GLYPH_HEIGHT = 7;
    localparam int GLYPH_W      = 40;
    localparam int COLOUR_W     = 24;
    localparam int CFG_IDX_W    = 2;
    localparam int PIXEL_TOTAL  = GLYPH_WIDTH * GLYPH_HEIGHT;
    localparam int COL_W        = (GLYPH_WIDTH > 1) ? $clog2(GLYPH_WIDTH) : 1;
    localparam int ROW_W        = (GLYPH_HEIGHT > 1) ? $clog2(GLYPH_HEIGHT) : 1;

    localparam logic [CFG_IDX_W-1:0] REG_FORMAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FG     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BG     = 2'd2;

    localparam logic [1:0] BYTES_TWO   = 2'd2;
    localparam logic [1:0] BYTES_THREE = 2'd3;

    typedef enum logic [1:0] {
        FMT_444 = 2'd0,
        FMT_565 = 2'd1,
        FMT_666 = 2'd2,
        FMT_888 = 2'd3
    } t_fmt;

    typedef struct packed {
        t_fmt                fmt;
        logic [COLOUR_W-1:0] fg;
        logic [COLOUR_W-1:0] bg;
    } t_cfg;

    typedef struct packed {
        logic valid;
        logic set;
        logic last;
    } t_scan;

endpackage

[hw/rtl/glyph_to_pixel_expander.sv]
// ----------------------------------------------------------------------------
// glyph_to_pixel_expander
// Expands a column-byte character glyph into panel-format pixel colour bytes.
// ----------------------------------------------------------------------------
// A glyph request is taken when start is high and busy is low. Its pixels come
// out row by row, left to right, one per cycle on o_strobe, the first after the
// scan and result registers; a glyph is GLYPH_WIDTH x GLYPH_HEIGHT pixels (35
// for 5x7), set by the row/column scan counter that steps one pixel a cycle.
// busy drops in the cycle before the last pixel of a glyph comes out, so a
// following request keeps the pixel stream free of gaps. Results cannot be
// held off: take each one in the cycle its strobe is high. Configuration writes
// are accepted at once and should be made only while no glyph is in flight.
module glyph_to_pixel_expander (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [gpe_pkg::GLYPH_W-1:0]    i_glyph_columns,
    output logic                           o_strobe,
    output logic [gpe_pkg::COLOUR_W-1:0]   o_pixel_bytes,
    output logic [1:0]                     o_byte_count,
    output logic                           o_last_pixel,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [gpe_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [gpe_pkg::COLOUR_W-1:0]   i_cfg_data
);
    import gpe_pkg::*;

    t_cfg  cfg;
    t_scan scan;

    gpe_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    gpe_scan u_scan (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_glyph_columns (i_glyph_columns),
        .o_scan          (scan)
    );

    gpe_pack u_pack (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_scan        (scan),
        .o_strobe      (o_strobe),
        .o_pixel_bytes (o_pixel_bytes),
        .o_byte_count  (o_byte_count),
        .o_last_pixel  (o_last_pixel)
    );

endmodule

[hw/rtl/gpe_cfg.sv]
// ----------------------------------------------------------------------------
// gpe_cfg
// Configuration registers: pixel format, foreground and background colour.
// ----------------------------------------------------------------------------
module gpe_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [gpe_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [gpe_pkg::COLOUR_W-1:0]   i_cfg_data,
    output gpe_pkg::t_cfg                  o_cfg
);
    import gpe_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fmt <= FMT_666;
            r_cfg.fg  <= {COLOUR_W{1'b1}};
            r_cfg.bg  <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_FORMAT: r_cfg.fmt <= t_fmt'(i_cfg_data[1:0]);
                REG_FG:     r_cfg.fg  <= i_cfg_data;
                REG_BG:     r_cfg.bg  <= i_cfg_data;
                default:    ;
            endcase
        end
    end

endmodule

[hw/rtl/gpe_scan.sv]
// ----------------------------------------------------------------------------
// gpe_scan
// Glyph register and row/column scan, one pixel bit a cycle in row-major order.
// ----------------------------------------------------------------------------
module gpe_scan (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [gpe_pkg::GLYPH_W-1:0]  i_glyph_columns,
    output gpe_pkg::t_scan               o_scan
);
    import gpe_pkg::*;

    logic [GLYPH_W-1:0] r_glyph;
    logic               r_active;
    logic [COL_W-1:0]   r_col;
    logic [ROW_W-1:0]   r_row;

    logic               at_col_end;
    logic               at_last;
    logic               accept;
    logic [63:0]        glyph_ext;
    logic [7:0]         col_byte;

    assign at_col_end = (r_col == COL_W'(GLYPH_WIDTH - 1));
    assign at_last    = at_col_end && (r_row == ROW_W'(GLYPH_HEIGHT - 1));
    assign busy       = r_active && !at_last;
    assign accept     = start && !busy;

    // columns past the input read as zero
    assign glyph_ext  = 64'(r_glyph);
    assign col_byte   = glyph_ext[{3'(r_col), 3'b000} +: 8];

    assign o_scan.valid = r_active;
    assign o_scan.set   = col_byte[3'(r_row)];
    assign o_scan.last  = at_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_col    <= '0;
            r_row    <= '0;
        end else if (accept) begin
            r_active <= 1'b1;
            r_col    <= '0;
            r_row    <= '0;
        end else if (r_active) begin
            if (at_last) begin
                r_active <= 1'b0;
                r_col    <= '0;
                r_row    <= '0;
            end else if (at_col_end) begin
                r_col    <= '0;
                r_row    <= r_row + 1'b1;
            end else begin
                r_col    <= r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_glyph <= i_glyph_columns;
        end
    end

endmodule

[hw/rtl/gpe_pack.sv]
// ----------------------------------------------------------------------------
// gpe_pack
// Colour select and panel-format packing into the result register.
// ----------------------------------------------------------------------------
module gpe_pack (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  gpe_pkg::t_cfg                 i_cfg,
    input  gpe_pkg::t_scan                i_scan,
    output logic                          o_strobe,
    output logic [gpe_pkg::COLOUR_W-1:0]  o_pixel_bytes,
    output logic [1:0]                    o_byte_count,
    output logic                          o_last_pixel
);
    import gpe_pkg::*;

    logic                r_strobe;
    logic [COLOUR_W-1:0] r_bytes;
    logic [1:0]          r_count;
    logic                r_last;

    logic [COLOUR_W-1:0] colour;
    logic [7:0]          red;
    logic [7:0]          green;
    logic [7:0]          blue;
    logic [COLOUR_W-1:0] n_bytes;
    logic [1:0]          n_count;

    // set glyph bit picks the background
    assign colour = i_scan.set ? i_cfg.bg : i_cfg.fg;
    assign red    = colour[23:16];
    assign green  = colour[15:8];
    assign blue   = colour[7:0];

    always_comb begin
        unique case (i_cfg.fmt)
            FMT_888: begin
                n_bytes = {red, green, blue};
                n_count = BYTES_THREE;
            end
            FMT_666: begin
                n_bytes = {red[5:0], 2'b00, green[5:0], 2'b00, blue[5:0], 2'b00};
                n_count = BYTES_THREE;
            end
            FMT_565: begin
                n_bytes = {8'h00, red[4:0], green[5:3], green[2:0], blue[4:0]};
                n_count = BYTES_TWO;
            end
            default: begin
                n_bytes = {8'h00, red[3:0], green[3:0], blue[3:0], 4'h0};
                n_count = BYTES_TWO;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            r_strobe <= i_scan.valid;
            r_last   <= i_scan.valid && i_scan.last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bytes <= n_bytes;
        r_count <= n_count;
    end

    assign o_strobe      = r_strobe;
    assign o_pixel_bytes = r_bytes;
    assign o_byte_count  = r_count;
    assign o_last_pixel  = r_last;

endmodule

[hw/rtl/gpe_checker.sv]
// ----------------------------------------------------------------------------
// gpe_checker
// Port-level checks of the glyph to pixel expander, bound to the top level.
// ----------------------------------------------------------------------------
module gpe_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    input  logic                           busy,
    input  logic [gpe_pkg::GLYPH_W-1:0]    i_glyph_columns,
    input  logic                           o_strobe,
    input  logic [gpe_pkg::COLOUR_W-1:0]   o_pixel_bytes,
    input  logic [1:0]                     o_byte_count,
    input  logic                           o_last_pixel,
    input  logic                           i_cfg_valid,
    input  logic                           o_cfg_ready,
    input  logic [gpe_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [gpe_pkg::COLOUR_W-1:0]   i_cfg_data
);
    import gpe_pkg::*;

    // first pixel of a request shows after the scan and result registers
    a_first_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_strobe)
        else $error("no first pixel after glyph request");

    a_first_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (PIXEL_TOTAL > 1)) |-> ##2 !o_last_pixel)
        else $error("first pixel marked last");

    // while busy a pixel is always in flight
    a_busy_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> o_strobe)
        else $error("busy without pixel output");

    a_last_strobed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_pixel |-> o_strobe)
        else $error("last pixel without strobe");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_byte_count == BYTES_TWO || o_byte_count == BYTES_THREE))
        else $error("byte count out of range");

endmodule

bind glyph_to_pixel_expander gpe_checker u_gpe_checker (.*);

[verif/pixel_stream_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pixel_stream_checker
// Watches the glyph, pixel and register channels of the glyph to pixel
// expander. Keeps its own copy of the colour registers, expands every
// accepted glyph into the pixels it should produce and compares each strobed
// pixel, field by field, with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module pixel_stream_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic                           i_busy,
    input  logic [gpe_pkg::GLYPH_W-1:0]    i_glyph_columns,
    input  logic                           i_strobe,
    input  logic [gpe_pkg::COLOUR_W-1:0]   i_pixel_bytes,
    input  logic [1:0]                     i_byte_count,
    input  logic                           i_last_pixel,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [gpe_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [gpe_pkg::COLOUR_W-1:0]   i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_glyph_count,
    output int                             o_pixel_count
);
    import gpe_pkg::*;

    typedef struct packed {
        logic [COLOUR_W-1:0] bytes;
        logic [1:0]          count;
        logic                last;
    } t_pixel;

    t_pixel              expected_pixels[$];
    t_pixel              want;
    t_fmt                fmt_q;
    logic [COLOUR_W-1:0] fg_q;
    logic [COLOUR_W-1:0] bg_q;
    int                  fail_count  = 0;
    int                  glyph_count = 0;
    int                  pixel_count = 0;

    assign o_fail_count  = fail_count;
    assign o_pending     = expected_pixels.size();
    assign o_glyph_count = glyph_count;
    assign o_pixel_count = pixel_count;

    function automatic t_pixel pack_colour(input t_fmt fmt, input logic [COLOUR_W-1:0] colour);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        t_pixel     p;
        r      = colour[23:16];
        g      = colour[15:8];
        b      = colour[7:0];
        p.last = 1'b0;
        case (fmt)
            FMT_888: begin
                p.bytes = {r, g, b};
                p.count = BYTES_THREE;
            end
            FMT_666: begin
                p.bytes = {r[5:0], 2'b00, g[5:0], 2'b00, b[5:0], 2'b00};
                p.count = BYTES_THREE;
            end
            FMT_565: begin
                p.bytes = {8'h00, r[4:0], g[5:3], g[2:0], b[4:0]};
                p.count = BYTES_TWO;
            end
            default: begin
                p.bytes = {8'h00, r[3:0], g[3:0], b[3:0], 4'h0};
                p.count = BYTES_TWO;
            end
        endcase
        return p;
    endfunction

    task automatic expand_glyph(input logic [GLYPH_W-1:0] glyph);
        logic [7:0] col_byte;
        t_pixel     p;
        for (int row = 0; row < GLYPH_HEIGHT; row++) begin
            for (int col = 0; col < GLYPH_WIDTH; col++) begin
                // columns past the input read as zero
                col_byte = (col * 8 < GLYPH_W) ? glyph[col * 8 +: 8] : 8'h00;
                p        = pack_colour(fmt_q, col_byte[row] ? bg_q : fg_q);
                p.last   = (row == GLYPH_HEIGHT - 1) && (col == GLYPH_WIDTH - 1);
                expected_pixels.push_back(p);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fmt_q = FMT_666;
            fg_q  = 24'hFFFFFF;
            bg_q  = 24'h000000;
            expected_pixels.delete();
        end else begin
            if (i_strobe) begin
                pixel_count++;
                if (expected_pixels.size() == 0) begin
                    $error("unexpected pixel: pixel_bytes %h byte_count %0d last_pixel %0b",
                           i_pixel_bytes, i_byte_count, i_last_pixel);
                    fail_count++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (i_pixel_bytes !== want.bytes) begin
                        $error("pixel_bytes: expected %h, got %h", want.bytes, i_pixel_bytes);
                        fail_count++;
                    end
                    if (i_byte_count !== want.count) begin
                        $error("byte_count: expected %0d, got %0d", want.count, i_byte_count);
                        fail_count++;
                    end
                    if (i_last_pixel !== want.last) begin
                        $error("last_pixel: expected %0b, got %0b", want.last, i_last_pixel);
                        fail_count++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                glyph_count++;
                expand_glyph(i_glyph_columns);
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_FORMAT: fmt_q = t_fmt'(i_cfg_data[1:0]);
                    REG_FG:     fg_q  = i_cfg_data;
                    REG_BG:     bg_q  = i_cfg_data;
                    default:    ;
                endcase
            end
        end
    end

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Top of the glyph to pixel expander testbench. Drives glyph requests and
// register writes: a directed pass over every pixel format and the colour
// extremes, then random glyphs and settings under several idling patterns.
// The checker beside the block predicts and compares; this module decides.
// ----------------------------------------------------------------------------
module tb;
    import gpe_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int ITEMS_PER_PHASE  = 140;
    localparam int CONFIG_EVERY     = 15;
    localparam int DRAIN_LIMIT      = 2000;
    localparam int TAIL_CYCLES      = 8;
    localparam int RUN_LIMIT_NS     = 5_000_000;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  start           = 1'b0;
    logic                  busy;
    logic [GLYPH_W-1:0]    i_glyph_columns = '0;
    logic                  o_strobe;
    logic [COLOUR_W-1:0]   o_pixel_bytes;
    logic [1:0]            o_byte_count;
    logic                  o_last_pixel;
    logic                  i_cfg_valid     = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index     = '0;
    logic [COLOUR_W-1:0]   i_cfg_data      = '0;

    int fail_count;
    int pending;
    int glyph_count;
    int pixel_count;

    always #10 i_clk = ~i_clk;

    glyph_to_pixel_expander dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_glyph_columns (i_glyph_columns),
        .o_strobe        (o_strobe),
        .o_pixel_bytes   (o_pixel_bytes),
        .o_byte_count    (o_byte_count),
        .o_last_pixel    (o_last_pixel),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    pixel_stream_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_glyph_columns (i_glyph_columns),
        .i_strobe        (o_strobe),
        .i_pixel_bytes   (o_pixel_bytes),
        .i_byte_count    (o_byte_count),
        .i_last_pixel    (o_last_pixel),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_glyph_count   (glyph_count),
        .o_pixel_count   (pixel_count)
    );

    initial begin
        #(RUN_LIMIT_NS);
        $display("TEST FAILED");
        $finish;
    end

    // idle cycles before a request, pct is the chance of idling each cycle
    function automatic int idle_gap(input int pct);
        int gap;
        gap = 0;
        while (gap < 60 && $urandom_range(99) < pct)
            gap++;
        if (pct > 0 && $urandom_range(3) == 0)
            gap += $urandom_range(40);
        return gap;
    endfunction

    function automatic logic [GLYPH_W-1:0] random_glyph();
        logic [63:0] a;
        logic [63:0] b;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        case ($urandom_range(3))
            0:       return a[GLYPH_W-1:0] & b[GLYPH_W-1:0];
            1:       return a[GLYPH_W-1:0] | b[GLYPH_W-1:0];
            default: return a[GLYPH_W-1:0];
        endcase
    endfunction

    function automatic logic [COLOUR_W-1:0] random_colour();
        case ($urandom_range(4))
            0:       return 24'h000000;
            1:       return 24'hFFFFFF;
            2:       return 24'hC0C0C0 | COLOUR_W'($urandom & 32'h000F0F0F);
            default: return COLOUR_W'($urandom);
        endcase
    endfunction

    // idle cycles are counted from the first cycle the block could take a request
    task automatic send_glyph(input logic [GLYPH_W-1:0] glyph, input int gap);
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            while (busy)
                @(negedge i_clk);
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start           <= 1'b1;
        i_glyph_columns <= glyph;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COLOUR_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // hold requests off until every pixel in flight has come out
    task automatic settle();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_config();
        write_reg(REG_FORMAT, COLOUR_W'($urandom));
        write_reg(REG_FG, random_colour());
        write_reg(REG_BG, random_colour());
        if ($urandom_range(3) == 0)
            write_reg(REG_UNUSED, COLOUR_W'($urandom));
    endtask

    initial begin
        int drain;
        int pct;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings, back to back
        send_glyph('0, 0);
        send_glyph('1, 0);
        send_glyph({5{8'h55}}, 0);
        send_glyph({5{8'hAA}}, 0);

        for (int f = 0; f < 4; f++) begin
            settle();
            write_reg(REG_FORMAT, COLOUR_W'(f));
            write_reg(REG_FG, 24'h000000);
            write_reg(REG_BG, 24'hFFFFFF);
            send_glyph({8'h7F, 8'h41, 8'h49, 8'h41, 8'h7F}, 0);
            settle();
            // high channel bits only against low channel bits only
            write_reg(REG_FG, 24'hE0C0E0);
            write_reg(REG_BG, 24'h1F3F1F);
            send_glyph({8'h80, 8'h00, 8'h2A, 8'h55, 8'hFF}, 0);
        end

        // unknown index must leave the settings alone
        settle();
        write_reg(REG_UNUSED, 24'hFFFFFF);
        send_glyph(random_glyph(), 0);

        for (int phase = 0; phase < 3; phase++) begin
            pct = (phase == 0) ? 0 : (phase == 1) ? 76 : 13;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n % CONFIG_EVERY == 0) begin
                    settle();
                    random_config();
                end
                send_glyph(random_glyph(), idle_gap(pct));
            end
        end

        @(negedge i_clk);
        start <= 1'b0;
        drain = 0;
        while (pending != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending != 0)
            $error("%0d pixels never arrived", pending);

        $display("run covered %0d glyphs and %0d pixels over all four pixel formats,",
                 glyph_count, pixel_count);
        $display("colour extremes, ignored register writes and three request idling patterns");
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/gpe_pkg.sv
hw/rtl/gpe_cfg.sv
hw/rtl/gpe_scan.sv
hw/rtl/gpe_pack.sv
hw/rtl/glyph_to_pixel_expander.sv
hw/rtl/gpe_checker.sv
verif/pixel_stream_checker.sv
verif/tb.sv
